### sv/lpm_pkg.sv
// shared types and constants for the like pattern matcher
`default_nettype none

package lpm_pkg;

   typedef enum logic [1:0] {
      OP_PAT_BYTE  = 2'd0,
      OP_PAT_END   = 2'd1,
      OP_SUBJ_BYTE = 2'd2,
      OP_SUBJ_END  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_LIT = 2'd0,
      KIND_ONE = 2'd1,
      KIND_RUN = 2'd2
   } token_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_ESCAPE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_TOKEN = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_BYTE  = 2'd2,
      CMD_END   = 2'd3
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type     op;
      logic           restart;
      logic           tok_en;
      token_kind_type kind;
      logic [7:0]     data;
      logic           esc;
   } cmd_type;

   localparam logic [7:0] CH_ESC = 8'h5C;
   localparam logic [7:0] CH_ONE = 8'h5F;
   localparam logic [7:0] CH_RUN = 8'h25;

   localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

### sv/lpm_front.sv
// front end: request decode and pattern tokenizing
`default_nettype none

module lpm_front
   import lpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       q_full,
   output logic            q_push,
   output cmd_type         q_cmd
);

   logic closed_ff, closed_in;
   logic escape_ff, escape_in;
   logic last_run_ff, last_run_in;
   logic accept;
   logic esc_eff;
   logic last_run_eff;
   opcode_type op;

   assign op        = opcode_type'(req_opcode);
   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign esc_eff   = ~closed_ff & escape_ff;
   assign last_run_eff = ~closed_ff & last_run_ff;

   always_comb begin
      q_cmd         = '0;
      q_cmd.data    = req_data_byte;
      q_cmd.restart = closed_ff;
      q_push        = 1'b0;
      closed_in     = closed_ff;
      escape_in     = escape_ff;
      last_run_in   = last_run_ff;
      unique case (op)
         OP_PAT_BYTE: begin
            q_cmd.op  = CMD_TOKEN;
            q_push    = accept;
            closed_in = 1'b0;
            escape_in = 1'b0;
            last_run_in = last_run_eff;
            if (esc_eff) begin
               q_cmd.tok_en = 1'b1;
               q_cmd.kind   = KIND_LIT;
               last_run_in  = 1'b0;
            end else if (req_data_byte == CH_ESC) begin
               escape_in = 1'b1;
            end else if (req_data_byte == CH_ONE) begin
               q_cmd.tok_en = 1'b1;
               q_cmd.kind   = KIND_ONE;
               q_cmd.data   = '0;
               last_run_in  = 1'b0;
            end else if (req_data_byte == CH_RUN) begin
               q_cmd.tok_en = ~last_run_eff;
               q_cmd.kind   = KIND_RUN;
               q_cmd.data   = '0;
               last_run_in  = 1'b1;
            end else begin
               q_cmd.tok_en = 1'b1;
               q_cmd.kind   = KIND_LIT;
               last_run_in  = 1'b0;
            end
         end
         OP_PAT_END: begin
            q_cmd.op    = CMD_CLOSE;
            q_cmd.esc   = esc_eff;
            q_push      = accept;
            closed_in   = 1'b1;
            escape_in   = 1'b0;
            last_run_in = 1'b0;
         end
         OP_SUBJ_BYTE: begin
            q_cmd.op = CMD_BYTE;
            q_push   = accept & closed_ff;
         end
         OP_SUBJ_END: begin
            q_cmd.op = CMD_END;
            q_push   = accept & closed_ff;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff   <= 1'b1;
         escape_ff   <= 1'b0;
         last_run_ff <= 1'b0;
      end else if (accept) begin
         closed_ff   <= closed_in;
         escape_ff   <= escape_in;
         last_run_ff <= last_run_in;
      end
   end

endmodule

`default_nettype wire

### sv/lpm_queue.sv
// short command queue between front end and scan engine
`default_nettype none

module lpm_queue
   import lpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### sv/lpm_back.sv
// back end: token store, bit-parallel scan engine and result register
`default_nettype none

module lpm_back
   import lpm_pkg::*;
#(
   parameter int MAX_TOKENS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire cmd_type head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic         rsp_matched,
   output logic [1:0]   rsp_pattern_status
);

   localparam int CW = $clog2(MAX_TOKENS + 1);
   localparam int IW = $clog2(MAX_TOKENS);

   token_kind_type    kind_ff [MAX_TOKENS];
   logic [7:0]        byte_ff [MAX_TOKENS];
   logic [CW-1:0]     count_ff, count_in;
   status_type        fault_ff, fault_in;
   logic [MAX_TOKENS:0] act_ff, act_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              matched_ff, matched_in;
   status_type        status_ff, status_in;

   logic [CW-1:0]       cnt_base;
   status_type          fault_base;
   logic                tok_wr;
   logic [MAX_TOKENS-1:0] lane_v;
   logic [MAX_TOKENS-1:0] run_v;
   logic [MAX_TOKENS-1:0] adv;
   logic [MAX_TOKENS:0] raw_step;
   logic [MAX_TOKENS:0] step_vec;
   logic [MAX_TOKENS:0] start_vec;
   logic                out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = head_valid & ((head_cmd.op != CMD_END) | out_free);

   // per-position lane logic
   always_comb begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         lane_v[i] = (CW'(i) < count_ff);
         run_v[i]  = lane_v[i] & (kind_ff[i] == KIND_RUN);
         adv[i]    = act_ff[i] & lane_v[i] & (kind_ff[i] != KIND_RUN) &
                     ((kind_ff[i] == KIND_ONE) || (byte_ff[i] == head_cmd.data));
      end
      raw_step = '0;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         raw_step[i]   = raw_step[i] | (act_ff[i] & run_v[i]);
         raw_step[i+1] = adv[i];
      end
      // collapsed runs never sit next to each other, so one hop closes the set
      step_vec     = raw_step;
      start_vec    = '0;
      start_vec[0] = 1'b1;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         step_vec[i+1]  = raw_step[i+1] | (raw_step[i] & run_v[i]);
         start_vec[i+1] = (i == 0) ? run_v[0] : 1'b0;
      end
   end

   always_comb begin
      cnt_base     = head_cmd.restart ? '0 : count_ff;
      fault_base   = head_cmd.restart ? STATUS_OK : fault_ff;
      count_in     = count_ff;
      fault_in     = fault_ff;
      act_in       = act_ff;
      tok_wr       = 1'b0;
      matched_in   = matched_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop) begin
         unique case (head_cmd.op)
            CMD_TOKEN: begin
               count_in = cnt_base;
               fault_in = fault_base;
               if (head_cmd.tok_en) begin
                  if (cnt_base == CW'(MAX_TOKENS)) begin
                     fault_in = STATUS_OVERFLOW;
                  end else begin
                     tok_wr   = 1'b1;
                     count_in = cnt_base + 1'b1;
                  end
               end
            end
            CMD_CLOSE: begin
               count_in = cnt_base;
               fault_in = fault_base;
               if (head_cmd.esc && fault_base == STATUS_OK) begin
                  fault_in = STATUS_ESCAPE;
               end
               if (head_cmd.restart) begin
                  act_in    = '0;
                  act_in[0] = 1'b1;
               end else begin
                  act_in = start_vec;
               end
            end
            CMD_BYTE: begin
               act_in = step_vec;
            end
            CMD_END: begin
               matched_in   = (fault_ff == STATUS_OK) & act_ff[count_ff];
               status_in    = fault_ff;
               rsp_valid_in = 1'b1;
               act_in       = start_vec;
            end
            default: begin
               act_in = act_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fault_ff     <= STATUS_OK;
         act_ff       <= {{MAX_TOKENS{1'b0}}, 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      status_ff  <= status_in;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (tok_wr && cnt_base[IW-1:0] == IW'(i)) begin
            kind_ff[i] <= head_cmd.kind;
            byte_ff[i] <= head_cmd.data;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = matched_ff;
   assign rsp_pattern_status = status_ff;

endmodule

`default_nettype wire

### sv/like_pattern_matcher_top.sv
// top level of the like pattern matcher
`default_nettype none

// Whole-string LIKE matcher. Load a pattern with pattern byte requests and a
// pattern end, then stream subject bytes and a subject end; each subject end
// returns one result (matched flag and pattern status). The block takes one
// request per clock while the command queue is not full: the front end
// tokenizes pattern bytes on the fly, and the scan engine updates every active
// pattern position at once, which sets the one-byte-per-clock rate. A subject
// end passes through the queue to the scan engine, which loads its result into
// the output register; the two-entry command queue lets input keep flowing while
// a result waits there. Subject requests sent while a pattern is open are dropped.
module like_pattern_matcher_top
   import lpm_pkg::*;
#(
   parameter int MAX_TOKENS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic [1:0]      rsp_pattern_status
);

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head;

   lpm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_push_cmd)
   );

   lpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   lpm_back #(
      .MAX_TOKENS (MAX_TOKENS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (q_valid),
      .head_cmd           (q_head),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_matched        (rsp_matched),
      .rsp_pattern_status (rsp_pattern_status)
   );

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.op == CMD_END) |=> rsp_valid)
      else $error("subject end left no result");

   a_match_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |-> (rsp_pattern_status == STATUS_OK))
      else $error("match reported on a faulted pattern");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> req_stall)
      else $error("request taken while queue full");

endmodule

`default_nettype wire
